/* src/ipv4dd_pkg.sv */
// Package for the dotted-decimal IPv4 address parser.
// Holds the parse phase type, character codes and the digit accumulate helper.
// No dependencies.
package ipv4dd_pkg;

    localparam int unsigned CHAR_W   = 8;
    localparam int unsigned OCTET_W  = 8;
    localparam int unsigned ACCUM_W  = 9;
    localparam int unsigned INDEX_W  = 2;
    localparam int unsigned OCTETS   = 4;

    // Character codes
    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

    // Largest legal octet value and the saturated "too big" marker
    localparam logic [ACCUM_W-1:0] OCTET_MAX = 9'd255;
    localparam logic [ACCUM_W-1:0] ACCUM_SAT = 9'd256;
    localparam logic [INDEX_W-1:0] LAST_OCTET = 2'd3;

    typedef enum logic [2:0] {
        PH_LEAD  = 3'd0,
        PH_DIGIT = 3'd1,
        PH_TRAIL = 3'd2,
        PH_DONE  = 3'd3,
        PH_ERR   = 3'd4
    } phase_t;

    // accum * 10 + digit, saturating at ACCUM_SAT for anything above 255
    function automatic logic [ACCUM_W-1:0] add_digit(
        input logic [ACCUM_W-1:0] acc,
        input logic [3:0]         digit
    );
        logic [ACCUM_W+3:0] prod;
        begin
            prod = {acc, 3'b000} + {2'b00, acc, 1'b0} + {{ACCUM_W{1'b0}}, digit};
            if (prod > {4'b0000, OCTET_MAX}) begin
                add_digit = ACCUM_SAT;
            end else begin
                add_digit = prod[ACCUM_W-1:0];
            end
        end
    endfunction

endpackage

/* src/ipv4_dotted_decimal_parser_core.sv */
// Dotted-decimal IPv4 address parser, one character per request.
// Depends on ipv4dd_pkg for the phase type, character codes and digit helper.
//
//  Channel   Ports                                   Direction  Carries
//  input     s_valid s_ready s_char_in               in         one character, NUL ends
//  result    m_valid m_ready m_addr_ok m_octet_a..d  out        one address per NUL
//
// One character a cycle is sustained while no NUL waits; a character is held in the input
// register and its result, if any, is loaded into the result register as it advances.
// The per-character step (phase update and the times-ten accumulate) is one short
// combinational pass between those two registers.
// A NUL waits in the input register while an earlier result is still untaken;
// other characters never stall. Reset is synchronous, active low.
module ipv4_dotted_decimal_parser_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [ipv4dd_pkg::CHAR_W-1:0]    s_char_in,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_addr_ok,
    output logic [ipv4dd_pkg::OCTET_W-1:0]   m_octet_a,
    output logic [ipv4dd_pkg::OCTET_W-1:0]   m_octet_b,
    output logic [ipv4dd_pkg::OCTET_W-1:0]   m_octet_c,
    output logic [ipv4dd_pkg::OCTET_W-1:0]   m_octet_d
);
    import ipv4dd_pkg::*;

    // Input register
    logic                 in_valid_reg;
    logic [CHAR_W-1:0]    char_reg;

    // Parse state
    phase_t               phase_reg, phase_next;
    logic [INDEX_W-1:0]   index_reg, index_next;
    logic [ACCUM_W-1:0]   accum_reg, accum_next;
    logic                 seen_reg, seen_next;
    logic [OCTET_W-1:0]   store_reg [OCTETS];
    logic                 store_we;
    logic [INDEX_W-1:0]   store_sel;

    // Result register
    logic                 out_valid_reg;
    logic                 ok_reg, ok_next;
    logic [OCTET_W-1:0]   oct_reg [OCTETS];
    logic [OCTET_W-1:0]   oct_next [OCTETS];

    logic                 is_nul, is_digit, is_space, is_dot;
    logic                 advance;
    logic [ACCUM_W-1:0]   accum_add;
    logic [3:0]           digit_val;

    // Decode the held character
    always_comb begin
        is_nul     = (char_reg == CHAR_NUL);
        is_space   = (char_reg == CHAR_SPACE);
        is_dot     = (char_reg == CHAR_DOT);
        is_digit   = (char_reg >= CHAR_ZERO) && (char_reg <= CHAR_NINE);
        digit_val  = 4'(char_reg - CHAR_ZERO);
        accum_add  = add_digit(accum_reg, digit_val);
    end

    // Advance unless a NUL would overwrite an untaken result
    assign advance = in_valid_reg && (!is_nul || !out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // Next parse state and result
    always_comb begin
        phase_next = phase_reg;
        index_next = index_reg;
        accum_next = accum_reg;
        seen_next  = seen_reg;
        store_we   = 1'b0;
        store_sel  = index_reg;
        ok_next    = 1'b0;
        for (int k = 0; k < OCTETS; k++) begin
            oct_next[k] = store_reg[k];
        end

        if (is_nul) begin
            if (phase_reg == PH_DONE) begin
                ok_next = 1'b1;
            end else if ((phase_reg == PH_DIGIT || phase_reg == PH_TRAIL) &&
                         index_reg == LAST_OCTET && seen_reg &&
                         accum_reg <= OCTET_MAX) begin
                ok_next     = 1'b1;
                oct_next[3] = accum_reg[OCTET_W-1:0];
            end
            if (!ok_next) begin
                for (int k = 0; k < OCTETS; k++) begin
                    oct_next[k] = '0;
                end
            end
            phase_next = PH_LEAD;
            index_next = '0;
            accum_next = '0;
            seen_next  = 1'b0;
        end else begin
            unique case (phase_reg)
                PH_LEAD: begin
                    if (is_digit) begin
                        accum_next = accum_add;
                        seen_next  = 1'b1;
                        phase_next = PH_DIGIT;
                    end else if (!is_space) begin
                        phase_next = PH_ERR;
                    end
                end
                PH_DIGIT, PH_TRAIL: begin
                    if (is_digit && phase_reg == PH_DIGIT) begin
                        accum_next = accum_add;
                        seen_next  = 1'b1;
                    end else if (is_space) begin
                        phase_next = PH_TRAIL;
                    end else if (is_dot) begin
                        // Close the octet
                        if (!seen_reg || accum_reg > OCTET_MAX) begin
                            phase_next = PH_ERR;
                        end else begin
                            store_we = 1'b1;
                            if (index_reg == LAST_OCTET) begin
                                phase_next = PH_DONE;
                            end else begin
                                index_next = index_reg + 1'b1;
                                phase_next = PH_LEAD;
                                accum_next = '0;
                                seen_next  = 1'b0;
                            end
                        end
                    end else begin
                        phase_next = PH_ERR;
                    end
                end
                PH_DONE: begin
                    phase_next = PH_DONE;
                end
                default: begin
                    phase_next = PH_ERR;
                end
            endcase
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_ready && s_valid) begin
            char_reg <= s_char_in;
        end
    end

    // Parse state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_LEAD;
            index_reg <= '0;
            accum_reg <= '0;
            seen_reg  <= 1'b0;
        end else if (advance) begin
            phase_reg <= phase_next;
            index_reg <= index_next;
            accum_reg <= accum_next;
            seen_reg  <= seen_next;
        end
        if (advance && store_we) begin
            store_reg[store_sel] <= accum_reg[OCTET_W-1:0];
        end
    end

    // Result register: load on a NUL, drop when taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && is_nul) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
        if (advance && is_nul) begin
            ok_reg <= ok_next;
            for (int k = 0; k < OCTETS; k++) begin
                oct_reg[k] <= oct_next[k];
            end
        end
    end

    assign m_valid   = out_valid_reg;
    assign m_addr_ok = ok_reg;
    assign m_octet_a = oct_reg[0];
    assign m_octet_b = oct_reg[1];
    assign m_octet_c = oct_reg[2];
    assign m_octet_d = oct_reg[3];

    // Checks
    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !ok_reg |->
            oct_reg[0] == '0 && oct_reg[1] == '0 && oct_reg[2] == '0 && oct_reg[3] == '0)
        else $error("invalid address carries non-zero octets");

    a_nul_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && is_nul |=>
            phase_reg == PH_LEAD && index_reg == '0 && accum_reg == '0 && !seen_reg)
        else $error("parse state not cleared after end of string");

    a_accum_range: assert property (@(posedge aclk) disable iff (!aresetn)
        accum_reg <= ACCUM_SAT)
        else $error("accumulator beyond saturation value");

    a_accum_needs_digit: assert property (@(posedge aclk) disable iff (!aresetn)
        !seen_reg |-> accum_reg == '0)
        else $error("accumulator non-zero without a digit");

    a_nul_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && is_nul && out_valid_reg && !m_ready |=> in_valid_reg && is_nul)
        else $error("end of string dropped while result pending");

endmodule

/* bench/tb_top.sv */
// Self-checking bench for the dotted-decimal IPv4 address parser core.
// Mirrors the parser per character, drives directed and random text, and checks each result.
// Depends on ipv4dd_pkg and ipv4_dotted_decimal_parser_core.
module tb_top;
    import ipv4dd_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_CHARS  = 475;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    logic [CHAR_W-1:0]    s_char_in = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    logic                 m_addr_ok;
    logic [OCTET_W-1:0]   m_octet_a;
    logic [OCTET_W-1:0]   m_octet_b;
    logic [OCTET_W-1:0]   m_octet_c;
    logic [OCTET_W-1:0]   m_octet_d;

    typedef struct packed {
        logic               ok;
        logic [OCTET_W-1:0] a;
        logic [OCTET_W-1:0] b;
        logic [OCTET_W-1:0] c;
        logic [OCTET_W-1:0] d;
    } addr_t;

    // Addresses the parser owes us, oldest first
    addr_t pending_addrs[$];

    // Mirror of the parser state
    phase_t              mir_phase;
    logic [INDEX_W-1:0]  mir_index;
    logic [ACCUM_W-1:0]  mir_accum;
    logic                mir_digit_seen;
    logic [OCTET_W-1:0]  mir_octets [OCTETS];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int chars_sent     = 0;
    int addrs_checked  = 0;
    int addrs_valid    = 0;
    int err_count      = 0;
    int cycle_count    = 0;

    ipv4_dotted_decimal_parser_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_char_in (s_char_in),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_addr_ok (m_addr_ok),
        .m_octet_a (m_octet_a),
        .m_octet_b (m_octet_b),
        .m_octet_c (m_octet_c),
        .m_octet_d (m_octet_d)
    );

    always #5 aclk = ~aclk;

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles", cycle_count);
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Parser mirror
    // ------------------------------------------------------------------

    // Shift in one decimal digit, pinning anything above 255 at the saturated marker
    function automatic logic [ACCUM_W-1:0] times_ten_plus(input logic [ACCUM_W-1:0] acc,
                                                          input logic [CHAR_W-1:0]  ch);
        int unsigned v;
        v = int'(acc) * 10 + int'(ch - CHAR_ZERO);
        return (v > int'(OCTET_MAX)) ? ACCUM_SAT : v[ACCUM_W-1:0];
    endfunction

    task automatic clear_mirror();
        mir_phase      = PH_LEAD;
        mir_index      = '0;
        mir_accum      = '0;
        mir_digit_seen = 1'b0;
        for (int k = 0; k < OCTETS; k++) mir_octets[k] = '0;
    endtask

    // Close the current octet at a dot
    task automatic close_octet();
        if (!mir_digit_seen || mir_accum > OCTET_MAX) begin
            mir_phase = PH_ERR;
        end else begin
            mir_octets[mir_index] = mir_accum[OCTET_W-1:0];
            if (mir_index == LAST_OCTET) begin
                mir_phase = PH_DONE;
            end else begin
                mir_index      = mir_index + 1'b1;
                mir_phase      = PH_LEAD;
                mir_accum      = '0;
                mir_digit_seen = 1'b0;
            end
        end
    endtask

    // Advance the mirror by one accepted character; a NUL queues an address
    task automatic parse_char(input logic [CHAR_W-1:0] ch);
        logic  is_digit;
        logic  ok;
        addr_t res;
        is_digit = (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
        if (ch == CHAR_NUL) begin
            ok = (mir_phase == PH_DONE);
            if ((mir_phase == PH_DIGIT || mir_phase == PH_TRAIL) && mir_index == LAST_OCTET &&
                mir_digit_seen && mir_accum <= OCTET_MAX) begin
                mir_octets[LAST_OCTET] = mir_accum[OCTET_W-1:0];
                ok = 1'b1;
            end
            res.ok = ok;
            res.a  = ok ? mir_octets[0] : '0;
            res.b  = ok ? mir_octets[1] : '0;
            res.c  = ok ? mir_octets[2] : '0;
            res.d  = ok ? mir_octets[3] : '0;
            pending_addrs.push_back(res);
            clear_mirror();
        end else begin
            case (mir_phase)
                PH_LEAD: begin
                    if (is_digit) begin
                        mir_accum      = times_ten_plus(mir_accum, ch);
                        mir_digit_seen = 1'b1;
                        mir_phase      = PH_DIGIT;
                    end else if (ch != CHAR_SPACE) begin
                        mir_phase = PH_ERR;
                    end
                end
                PH_DIGIT: begin
                    if (is_digit) begin
                        mir_accum      = times_ten_plus(mir_accum, ch);
                        mir_digit_seen = 1'b1;
                    end else if (ch == CHAR_SPACE) begin
                        mir_phase = PH_TRAIL;
                    end else if (ch == CHAR_DOT) begin
                        close_octet();
                    end else begin
                        mir_phase = PH_ERR;
                    end
                end
                PH_TRAIL: begin
                    if (ch == CHAR_DOT) begin
                        close_octet();
                    end else if (ch != CHAR_SPACE) begin
                        mir_phase = PH_ERR;
                    end
                end
                PH_DONE: begin
                    // hold: rest of the text is ignored
                end
                default: begin
                    mir_phase = PH_ERR;
                end
            endcase
        end
    endtask

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Offer one character, idling beforehand at the current rate, and wait for acceptance
    task automatic send_char(input logic [CHAR_W-1:0] ch);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_char_in <= ch;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        parse_char(ch);
        chars_sent++;
    endtask

    // Send a string followed by its NUL terminator
    task automatic send_text(input string txt);
        for (int i = 0; i < txt.len(); i++) send_char(txt[i]);
        send_char(CHAR_NUL);
    endtask

    // Hold off requests until every queued address has come back
    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_addrs.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // Random text
    // ------------------------------------------------------------------

    function automatic int unsigned pick_octet();
        case ($urandom_range(7))
            0:       return 0;
            1:       return 255;
            2:       return $urandom_range(1, 9);
            default: return $urandom_range(255);
        endcase
    endfunction

    // Legal address with random spacing, leading zeros and sometimes ignored tail text
    function automatic string well_formed_text();
        string s;
        string num;
        string one;
        s   = "";
        one = " ";
        for (int k = 0; k < OCTETS; k++) begin
            if (k != 0) s = {s, "."};
            if ($urandom_range(3) == 0) repeat ($urandom_range(1, 2)) s = {s, " "};
            num = $sformatf("%0d", pick_octet());
            if ($urandom_range(9) == 0) repeat ($urandom_range(1, 3)) num = {"0", num};
            s = {s, num};
            if ($urandom_range(3) == 0) repeat ($urandom_range(1, 2)) s = {s, " "};
        end
        if ($urandom_range(4) == 0) begin
            s = {s, "."};
            repeat ($urandom_range(0, 5)) begin
                one.putc(0, byte'($urandom_range(1, 255)));
                s = {s, one};
            end
        end
        return s;
    endfunction

    // Legal address with one defect: a stray byte, a cut, an inserted character or a big octet
    function automatic string broken_text();
        string s;
        string ins;
        int    p;
        s = well_formed_text();
        case ($urandom_range(3))
            0: s.putc($urandom_range(s.len() - 1), byte'($urandom_range(1, 255)));
            1: s = s.substr(0, $urandom_range(s.len() - 1));
            2: begin
                case ($urandom_range(3))
                    0:       ins = " ";
                    1:       ins = ".";
                    2:       ins = "9";
                    default: ins = "0";
                endcase
                p = $urandom_range(s.len());
                s = {s.substr(0, p - 1), ins, s.substr(p, s.len() - 1)};
            end
            default: s = {$sformatf("%0d.", $urandom_range(256, 99999)), s};
        endcase
        return s;
    endfunction

    task automatic random_traffic(input int n_chars);
        int target;
        int pick;
        target = chars_sent + n_chars;
        while (chars_sent < target) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                send_text(well_formed_text());
            end else if (pick < 90) begin
                send_text(broken_text());
            end else begin
                // raw bytes over the full code range, NUL included
                repeat ($urandom_range(1, 8)) send_char(CHAR_W'($urandom_range(255)));
                send_char(CHAR_NUL);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    task automatic test_directed_cases();
        string tail;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_text("255.255.255.255");
        send_text("0.0.0.0");
        send_text("  007 . 10 .1. 099  ");
        // text after the closing dot is ignored, high codes included
        tail = "1.2.3.4.x";
        tail.putc(8, 8'hFF);
        send_text(tail);
        send_text("256.1.1.1");
        send_text("9.9.9.1234567");
        send_text("1..2.3");
        send_text("");
        send_text("1 2.3.4");
        send_char(8'hC8);
        send_text("1.2.3.4");
        send_text("1.2");
        send_text("x1.2.3.4");
        drain_results();
    endtask

    task automatic test_slow_receiver();
        send_idle_pct  = 7;
        recv_stall_pct = 68;
        random_traffic(RANDOM_CHARS);
        drain_results();
    endtask

    task automatic test_slow_sender();
        send_idle_pct  = 68;
        recv_stall_pct = 7;
        random_traffic(RANDOM_CHARS);
        drain_results();
    endtask

    task automatic test_full_rate();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        random_traffic(RANDOM_CHARS);
        drain_results();
    endtask

    // ------------------------------------------------------------------
    // Result side: pace m_ready and check each address against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : result_check
        addr_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_addrs.size() == 0) begin
                $error("address result with none expected");
                err_count++;
            end else begin
                want = pending_addrs.pop_front();
                addrs_checked++;
                if (m_addr_ok) addrs_valid++;
                if (m_addr_ok !== want.ok) begin
                    $error("addr_ok: expected %0d, got %0d", want.ok, m_addr_ok);
                    err_count++;
                end
                if (m_octet_a !== want.a) begin
                    $error("octet_a: expected %0d, got %0d", want.a, m_octet_a);
                    err_count++;
                end
                if (m_octet_b !== want.b) begin
                    $error("octet_b: expected %0d, got %0d", want.b, m_octet_b);
                    err_count++;
                end
                if (m_octet_c !== want.c) begin
                    $error("octet_c: expected %0d, got %0d", want.c, m_octet_c);
                    err_count++;
                end
                if (m_octet_d !== want.d) begin
                    $error("octet_d: expected %0d, got %0d", want.d, m_octet_d);
                    err_count++;
                end
            end
        end
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        clear_mirror();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_cases();
        test_slow_receiver();
        test_slow_sender();
        test_full_rate();

        // let anything still in flight surface as an unexpected result
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (pending_addrs.size() != 0) begin
            $error("%0d addresses never returned", pending_addrs.size());
            err_count++;
        end

        $display("Fed %0d characters of directed, well-formed, defective and raw text;",
                 chars_sent);
        $display("checked %0d addresses (%0d valid) under three pacing regimes, %0d errors.",
                 addrs_checked, addrs_valid, err_count);
        if (err_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
